FILE: design/piecewise_linear_lookup_interp_top_macros.svh
// Assertion macros for the lookup-interpolation controller.
`ifndef PIECEWISE_LINEAR_LOOKUP_INTERP_TOP_MACROS_SVH
`define PIECEWISE_LINEAR_LOOKUP_INTERP_TOP_MACROS_SVH
`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset.
`define PLVI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define PLVI_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define PLVI_ASSERT(label, prop, msg)
`define PLVI_NEVER(label, cond, msg)
`endif
`endif

FILE: design/plvi_pkg.sv
// Types, codes and constants for the lookup-interpolation block.
`default_nettype none
package plvi_pkg;

  localparam int unsigned DefTableDepth = 16;

  localparam logic [14:0] FarLimitRst   = 15'd3200;
  localparam logic [15:0] FarVelTopRst  = 16'd10000;
  localparam logic [15:0] FarVelLowRst  = 16'd60000;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [1:0] CFG_FAR_LIMIT   = 2'd0;
  localparam logic [1:0] CFG_FAR_VEL_TOP = 2'd1;
  localparam logic [1:0] CFG_FAR_VEL_LOW = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic               table_select;
    logic signed [15:0] distance;
    logic [15:0]        point_velocity_in;
  } in_item_t;

  typedef struct packed {
    logic [15:0] velocity;
    logic        in_span;
    logic [1:0]  status;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_INS_RD,
    OP_INS_CMP,
    OP_Q_TMIN,
    OP_Q_TMAX,
    OP_Q_SPAN,
    OP_Q_LAST,
    OP_Q_FIRST,
    OP_SCAN,
    OP_MUL,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_FIX,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    logic full;
    logic j_zero;
    logic gt;
    logic early;
    logic last_hit;
    logic first_hit;
    logic scan_more;
    logic div_last;
  } dp_stat_t;

endpackage
`default_nettype wire

FILE: design/plvi_dp.sv
// Datapath: point tables, config registers, search, multiply and divide.
`default_nettype none
module plvi_dp import plvi_pkg::*; #(
  parameter int unsigned TableDepth = DefTableDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dp_op_e      op_i,
  input  wire in_item_t    in_data_i,
  input  wire logic        cfg_valid_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  output dp_stat_t         stat_o,
  output out_item_t        res_o
);
  localparam int unsigned IW = $clog2(TableDepth);
  localparam int unsigned CW = $clog2(TableDepth + 1);
  localparam int unsigned AW = $clog2(2 * TableDepth);

  logic signed [15:0] dist_mem [2*TableDepth];
  logic [15:0]        speed_mem [2*TableDepth];

  logic [14:0] far_limit_q;
  logic [15:0] far_vel_top_q, far_vel_low_q;
  logic [CW-1:0] cnt_lo_q, cnt_hi_q;
  logic        t_q;
  logic signed [15:0] d_q, d1_q, d2_q, tmin_q, rdist_q;
  logic [15:0] vin_q, v1_q, v2_q, rspeed_q, den_q, rem_q, vel_q;
  logic [CW-1:0] j_q;
  logic [IW-1:0] i_q;
  logic signed [33:0] prod_q;
  logic        neg_q, span_q;
  logic [31:0] quo_q;
  logic [4:0]  dcnt_q;
  logic [1:0]  st_q;
  out_item_t   res_q;

  logic [CW-1:0] cur_cnt, in_cnt, last_idx, top_last_idx, j_m1, i_p2;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          we, wr_new;
  logic signed [15:0] far_s;
  logic signed [16:0] dv, dd;
  logic [33:0]   mag;
  logic [16:0]   trial;
  logic          ge;
  logic signed [17:0] qv, velsum;

  function automatic logic [AW-1:0] addr_of(input logic t, input logic [IW-1:0] idx);
    addr_of = t ? AW'(TableDepth) + AW'(idx) : AW'(idx);
  endfunction

  assign cur_cnt      = t_q ? cnt_hi_q : cnt_lo_q;
  assign in_cnt       = in_data_i.table_select ? cnt_hi_q : cnt_lo_q;
  assign last_idx     = cur_cnt - CW'(1);
  assign top_last_idx = cnt_hi_q - CW'(1);
  assign j_m1         = j_q - CW'(1);
  assign i_p2         = CW'(i_q) + CW'(2);
  assign far_s        = $signed({1'b0, far_limit_q});

  assign stat_o.full      = (cur_cnt == CW'(TableDepth));
  assign stat_o.j_zero    = (j_q == '0);
  assign stat_o.gt        = (rdist_q > d_q);
  assign stat_o.early     = (d_q <= 16'sd0) || (d_q > far_s) || (cur_cnt == '0);
  assign stat_o.last_hit  = (d_q >= rdist_q);
  assign stat_o.first_hit = (d_q <= rdist_q);
  assign stat_o.scan_more = (i_p2 < cur_cnt) && (rdist_q <= d_q);
  assign stat_o.div_last  = (dcnt_q == 5'd31);

  always_comb begin
    rd_addr = '0;
    case (op_i)
      OP_INS_RD:  rd_addr = addr_of(t_q, j_m1[IW-1:0]);
      OP_Q_TMIN:  rd_addr = addr_of(1'b1, '0);
      OP_Q_TMAX:  rd_addr = addr_of(1'b1, top_last_idx[IW-1:0]);
      OP_Q_SPAN:  rd_addr = addr_of(t_q, last_idx[IW-1:0]);
      OP_Q_LAST:  rd_addr = addr_of(t_q, '0);
      OP_Q_FIRST: rd_addr = addr_of(t_q, IW'(1));
      OP_SCAN:    rd_addr = addr_of(t_q, i_p2[IW-1:0]);
      default:    rd_addr = '0;
    endcase
  end

  always_comb begin
    we     = 1'b0;
    wr_new = 1'b1;
    case (op_i)
      OP_INS_RD:  we = !stat_o.full && stat_o.j_zero;
      OP_INS_CMP: begin
        we     = 1'b1;
        wr_new = !stat_o.gt;
      end
      default:    we = 1'b0;
    endcase
  end
  assign wr_addr = addr_of(t_q, j_q[IW-1:0]);

  always_ff @(posedge clk_i) begin
    if (we) begin
      dist_mem[wr_addr]  <= wr_new ? d_q : rdist_q;
      speed_mem[wr_addr] <= wr_new ? vin_q : rspeed_q;
    end
    rdist_q  <= dist_mem[rd_addr];
    rspeed_q <= speed_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      far_limit_q   <= FarLimitRst;
      far_vel_top_q <= FarVelTopRst;
      far_vel_low_q <= FarVelLowRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_FAR_LIMIT:   far_limit_q   <= cfg_data_i[14:0];
        CFG_FAR_VEL_TOP: far_vel_top_q <= cfg_data_i;
        CFG_FAR_VEL_LOW: far_vel_low_q <= cfg_data_i;
        default:         far_limit_q   <= far_limit_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_lo_q <= '0;
      cnt_hi_q <= '0;
    end else if (op_i == OP_LOAD && in_data_i.command == CMD_CLEAR) begin
      if (in_data_i.table_select) cnt_hi_q <= '0;
      else cnt_lo_q <= '0;
    end else if (we && wr_new) begin
      if (t_q) cnt_hi_q <= cnt_hi_q + CW'(1);
      else cnt_lo_q <= cnt_lo_q + CW'(1);
    end
  end

  assign dv    = $signed({1'b0, v2_q}) - $signed({1'b0, v1_q});
  assign dd    = $signed({d_q[15], d_q}) - $signed({d1_q[15], d1_q});
  assign mag   = prod_q[33] ? 34'(-prod_q) : 34'(prod_q);
  assign trial = {rem_q, quo_q[31]};
  assign ge    = trial >= {1'b0, den_q};
  assign qv    = neg_q ? (-$signed({2'b00, quo_q[15:0]}) - $signed({17'd0, rem_q != '0}))
                       : $signed({2'b00, quo_q[15:0]});
  assign velsum = $signed({2'b00, v1_q}) + qv;

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD: begin
        t_q    <= in_data_i.table_select;
        d_q    <= in_data_i.distance;
        vin_q  <= in_data_i.point_velocity_in;
        j_q    <= in_cnt;
        vel_q  <= '0;
        span_q <= 1'b0;
        if (in_data_i.command == CMD_INSERT && in_cnt == CW'(TableDepth)) st_q <= ST_FULL;
        else if (in_data_i.command == CMD_QUERY && in_cnt == '0) st_q <= ST_EMPTY;
        else st_q <= ST_OK;
      end
      OP_INS_CMP: if (stat_o.gt) j_q <= j_m1;
      OP_Q_TMAX:  tmin_q <= rdist_q;
      OP_Q_SPAN: begin
        span_q <= (cnt_hi_q != '0) && (d_q >= tmin_q) && (d_q <= rdist_q);
        if (d_q > 16'sd0 && d_q > far_s) vel_q <= t_q ? far_vel_top_q : far_vel_low_q;
      end
      OP_Q_LAST:  if (stat_o.last_hit) vel_q <= rspeed_q;
      OP_Q_FIRST: begin
        if (stat_o.first_hit) vel_q <= rspeed_q;
        d1_q <= rdist_q;
        v1_q <= rspeed_q;
        i_q  <= '0;
      end
      OP_SCAN: begin
        // advance while the next point still lies at or below the distance
        if (stat_o.scan_more) begin
          d1_q <= rdist_q;
          v1_q <= rspeed_q;
          i_q  <= i_q + IW'(1);
        end else begin
          d2_q <= rdist_q;
          v2_q <= rspeed_q;
        end
      end
      OP_MUL: begin
        prod_q <= dv * dd;
        den_q  <= 16'(d2_q - d1_q);
      end
      OP_DIV_INIT: begin
        neg_q  <= prod_q[33];
        quo_q  <= mag[31:0];
        rem_q  <= '0;
        dcnt_q <= '0;
      end
      OP_DIV_STEP: begin
        rem_q  <= ge ? 16'(trial - {1'b0, den_q}) : trial[15:0];
        quo_q  <= {quo_q[30:0], ge};
        dcnt_q <= dcnt_q + 5'd1;
      end
      OP_FIX:  vel_q <= velsum[15:0];
      OP_EMIT: begin
        res_q.velocity <= vel_q;
        res_q.in_span  <= span_q;
        res_q.status   <= st_q;
      end
      default: vel_q <= vel_q;
    endcase
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

FILE: design/plvi_ctrl.sv
// Controller: sequences clear, insert and query through the datapath.
`default_nettype none
`include "piecewise_linear_lookup_interp_top_macros.svh"
module plvi_ctrl import plvi_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [1:0] in_cmd_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire dp_stat_t   stat_i,
  output dp_op_e          op_o
);
  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_INS_RD  = 4'd1;
  localparam logic [3:0] S_INS_CMP = 4'd2;
  localparam logic [3:0] S_Q_TMIN  = 4'd3;
  localparam logic [3:0] S_Q_TMAX  = 4'd4;
  localparam logic [3:0] S_Q_SPAN  = 4'd5;
  localparam logic [3:0] S_Q_LAST  = 4'd6;
  localparam logic [3:0] S_Q_FIRST = 4'd7;
  localparam logic [3:0] S_SCAN    = 4'd8;
  localparam logic [3:0] S_MUL     = 4'd9;
  localparam logic [3:0] S_DIVI    = 4'd10;
  localparam logic [3:0] S_DIVS    = 4'd11;
  localparam logic [3:0] S_FIX     = 4'd12;
  localparam logic [3:0] S_WB      = 4'd13;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       emit;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign emit        = (state_q == S_WB) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    case (state_q)
      S_IDLE: if (in_valid_i) begin
        op_o = OP_LOAD;
        if (in_cmd_i == CMD_INSERT) state_d = S_INS_RD;
        else if (in_cmd_i == CMD_QUERY) state_d = S_Q_TMIN;
        else state_d = S_WB;
      end
      S_INS_RD: begin
        op_o    = OP_INS_RD;
        state_d = (stat_i.full || stat_i.j_zero) ? S_WB : S_INS_CMP;
      end
      S_INS_CMP: begin
        op_o    = OP_INS_CMP;
        state_d = stat_i.gt ? S_INS_RD : S_WB;
      end
      S_Q_TMIN: begin
        op_o    = OP_Q_TMIN;
        state_d = S_Q_TMAX;
      end
      S_Q_TMAX: begin
        op_o    = OP_Q_TMAX;
        state_d = S_Q_SPAN;
      end
      S_Q_SPAN: begin
        op_o    = OP_Q_SPAN;
        state_d = stat_i.early ? S_WB : S_Q_LAST;
      end
      S_Q_LAST: begin
        op_o    = OP_Q_LAST;
        state_d = stat_i.last_hit ? S_WB : S_Q_FIRST;
      end
      S_Q_FIRST: begin
        op_o    = OP_Q_FIRST;
        state_d = stat_i.first_hit ? S_WB : S_SCAN;
      end
      S_SCAN: begin
        op_o    = OP_SCAN;
        state_d = stat_i.scan_more ? S_SCAN : S_MUL;
      end
      S_MUL: begin
        op_o    = OP_MUL;
        state_d = S_DIVI;
      end
      S_DIVI: begin
        op_o    = OP_DIV_INIT;
        state_d = S_DIVS;
      end
      S_DIVS: begin
        op_o    = OP_DIV_STEP;
        state_d = stat_i.div_last ? S_FIX : S_DIVS;
      end
      S_FIX: begin
        op_o    = OP_FIX;
        state_d = S_WB;
      end
      S_WB: if (emit) begin
        op_o    = OP_EMIT;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // hold the result until the transfer completes
  assign out_valid_d = emit ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  `PLVI_ASSERT(a_stay_idle, (state_q == S_IDLE && !in_valid_i) |=> (state_q == S_IDLE), "left idle without a transfer")
  `PLVI_ASSERT(a_div_runs, (state_q == S_DIVS && !stat_i.div_last) |=> (state_q == S_DIVS), "divide cut short")
  `PLVI_ASSERT(a_wb_emits, (state_q == S_WB && !out_valid_q) |=> out_valid_q, "result not presented")

endmodule
`default_nettype wire

FILE: design/piecewise_linear_lookup_interp_top.sv
// Top level of the two-table piecewise linear velocity lookup.
// Input channel: in_valid_i/in_ready_o carry one in_item_t per transfer
// (clear, insert or query on the low or top table). Output channel:
// out_valid_o/out_ready_i return one out_item_t for every input item.
// Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i
// writes far_limit, far_velocity_top, far_velocity_low; always ready.
// Sequence per item: clear or no-op goes straight to write-back; insert
// alternates a table read and a compare for each point shifted up, then
// writes the new point; query reads the top table bounds and the span,
// may end early with a clamped velocity, else scans for the segment, then
// multiplies, divides and adds. The divider is a 32-step one-bit divider,
// and the tables have a single read port.
// in_ready_o is high only in idle, so an item is not taken until the
// previous one is through; a new item is taken while the previous
// result waits in the output register.
// Reset empties both tables and loads the config defaults; point storage
// is not cleared, so no reset pass is needed.
// When the receiver stalls, the result holds and the next finished item
// waits before its write-back until the output register frees.
`default_nettype none
module piecewise_linear_lookup_interp_top import plvi_pkg::*; #(
  parameter int unsigned TableDepth = DefTableDepth
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire in_item_t    in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output out_item_t        out_data_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  dp_op_e   op;
  dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  plvi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (in_data_i.command),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .op_o        (op)
  );

  plvi_dp #(.TableDepth(TableDepth)) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (op),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .stat_o      (stat),
    .res_o       (out_data_o)
  );

endmodule
`default_nettype wire
